// ----- rtl/ptow_pkg.sv -----
// ----------------------------------------------------------------------------
// ptow_pkg
// Shared types, command codes and the 5x7 font for the page-mode text writer.
// ----------------------------------------------------------------------------
`default_nettype none

package ptow_pkg;

    // Widths fixed by the interface
    localparam int CHAR_W   = 8;
    localparam int PAGE_W   = 4;
    localparam int COL_W    = 7;
    localparam int PACKET_W = 48;
    localparam int GLYPH_W  = 40;
    localparam int GIDX_W   = 6;
    localparam int NCMD_W   = 3;
    localparam int MAX_CMDS = 6;

    // Controller command codes
    localparam logic [7:0] CMD_PAGE   = 8'hB0;
    localparam logic [7:0] CMD_COL_LO = 8'h00;
    localparam logic [7:0] CMD_COL_HI = 8'h10;

    // Special characters
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_LF     = 8'h0A;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_DASH   = 8'h2D;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_SLASH  = 8'h2F;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam logic [7:0] CHAR_COLON  = 8'h3A;
    localparam logic [7:0] CHAR_UP_A   = 8'h41;
    localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
    localparam logic [7:0] CHAR_LO_A   = 8'h61;
    localparam logic [7:0] CHAR_LO_Z   = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;
    localparam logic [7:0] CHAR_HIGH   = 8'h80;
    localparam logic [7:0] CHAR_CONT_LAST = 8'hBF;

    // Glyph slots in the font
    localparam logic [GIDX_W-1:0] G_BLANK   = 6'd0;
    localparam logic [GIDX_W-1:0] G_DIGIT   = 6'd1;
    localparam logic [GIDX_W-1:0] G_LETTER  = 6'd11;
    localparam logic [GIDX_W-1:0] G_DASH    = 6'd37;
    localparam logic [GIDX_W-1:0] G_DOT     = 6'd38;
    localparam logic [GIDX_W-1:0] G_COLON   = 6'd39;
    localparam logic [GIDX_W-1:0] G_SLASH   = 6'd40;
    localparam logic [GIDX_W-1:0] G_UNKNOWN = 6'd41;

    localparam int GLYPH_ADVANCE = 6;

    typedef logic [2:0][7:0]          t_cmd_triple;
    typedef logic [MAX_CMDS-1:0][7:0] t_cmd_list;

    // Writes that one text byte expands into: commands first, then a packet
    typedef struct packed {
        logic [NCMD_W-1:0]   ncmd;
        t_cmd_list           cmds;
        logic                pkt_en;
        logic [PACKET_W-1:0] pkt;
    } t_plan;

    // Cursor commands for a page and column
    function automatic t_cmd_triple cursor_cmds(input logic [PAGE_W-1:0] page,
                                                input logic [COL_W-1:0]  col);
        t_cmd_triple t;
        t[0] = CMD_PAGE   | {4'b0, page};
        t[1] = CMD_COL_LO | {4'b0, col[3:0]};
        t[2] = CMD_COL_HI | {5'b0, col[6:4]};
        return t;
    endfunction

    // Map a byte to its font slot (letters folded to upper case)
    function automatic logic [GIDX_W-1:0] glyph_index(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] u;
        logic [GIDX_W-1:0] g;
        u = c;
        if (c inside {[CHAR_LO_A:CHAR_LO_Z]}) u = c - CASE_OFFSET;
        if (c >= CHAR_HIGH)                          g = G_UNKNOWN;
        else if (c == CHAR_SPACE)                    g = G_BLANK;
        else if (c inside {[CHAR_ZERO:CHAR_NINE]})   g = G_DIGIT + GIDX_W'(c - CHAR_ZERO);
        else if (u inside {[CHAR_UP_A:CHAR_UP_Z]})   g = G_LETTER + GIDX_W'(u - CHAR_UP_A);
        else if (c == CHAR_DASH)                     g = G_DASH;
        else if (c == CHAR_DOT)                      g = G_DOT;
        else if (c == CHAR_COLON)                    g = G_COLON;
        else if (c == CHAR_SLASH)                    g = G_SLASH;
        else                                         g = G_UNKNOWN;
        return g;
    endfunction

    // 5x7 font, column 0 in bits 7:0
    function automatic logic [GLYPH_W-1:0] font_row(input logic [GIDX_W-1:0] g);
        logic [GLYPH_W-1:0] r;
        case (g)
            6'd0:    r = 40'h00_00_00_00_00;
            6'd1:    r = 40'h3E_45_49_51_3E;
            6'd2:    r = 40'h00_40_7F_42_00;
            6'd3:    r = 40'h46_49_51_61_42;
            6'd4:    r = 40'h31_4B_45_41_21;
            6'd5:    r = 40'h10_7F_12_14_18;
            6'd6:    r = 40'h39_45_45_45_27;
            6'd7:    r = 40'h30_49_49_4A_3C;
            6'd8:    r = 40'h03_05_09_71_01;
            6'd9:    r = 40'h36_49_49_49_36;
            6'd10:   r = 40'h1E_29_49_49_06;
            6'd11:   r = 40'h7E_11_11_11_7E;
            6'd12:   r = 40'h36_49_49_49_7F;
            6'd13:   r = 40'h22_41_41_41_3E;
            6'd14:   r = 40'h1C_22_41_41_7F;
            6'd15:   r = 40'h41_49_49_49_7F;
            6'd16:   r = 40'h01_09_09_09_7F;
            6'd17:   r = 40'h7A_49_49_41_3E;
            6'd18:   r = 40'h7F_08_08_08_7F;
            6'd19:   r = 40'h00_41_7F_41_00;
            6'd20:   r = 40'h01_3F_41_40_20;
            6'd21:   r = 40'h41_22_14_08_7F;
            6'd22:   r = 40'h40_40_40_40_7F;
            6'd23:   r = 40'h7F_02_0C_02_7F;
            6'd24:   r = 40'h7F_10_08_04_7F;
            6'd25:   r = 40'h3E_41_41_41_3E;
            6'd26:   r = 40'h06_09_09_09_7F;
            6'd27:   r = 40'h5E_21_51_41_3E;
            6'd28:   r = 40'h46_29_19_09_7F;
            6'd29:   r = 40'h31_49_49_49_46;
            6'd30:   r = 40'h01_01_7F_01_01;
            6'd31:   r = 40'h3F_40_40_40_3F;
            6'd32:   r = 40'h1F_20_40_20_1F;
            6'd33:   r = 40'h3F_40_38_40_3F;
            6'd34:   r = 40'h63_14_08_14_63;
            6'd35:   r = 40'h07_08_70_08_07;
            6'd36:   r = 40'h43_45_49_51_61;
            6'd37:   r = 40'h08_08_08_08_08;
            6'd38:   r = 40'h00_00_60_60_00;
            6'd39:   r = 40'h00_00_36_36_00;
            6'd40:   r = 40'h02_04_08_10_20;
            default: r = 40'h06_09_51_01_02;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ptow_plan.sv -----
// ----------------------------------------------------------------------------
// ptow_plan
// Holds the text cursor and turns one text byte into its list of writes.
// ----------------------------------------------------------------------------
`default_nettype none

module ptow_plan
    import ptow_pkg::*;
#(
    parameter int SCREEN_COLUMNS = 128,
    parameter int SCREEN_PAGES   = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire logic [CHAR_W-1:0] i_char_code,
    input  wire logic              i_first,
    output t_plan                  o_plan
);

    localparam logic [COL_W:0]  COL_LIMIT  = (COL_W+1)'(SCREEN_COLUMNS);
    localparam logic [PAGE_W:0] PAGE_LIMIT = (PAGE_W+1)'(SCREEN_PAGES);

    logic [PAGE_W-1:0] r_page, n_page;
    logic [COL_W-1:0]  r_col,  n_col;
    logic              r_skip, n_skip;
    logic              r_done, n_done;

    // Effective cursor after an optional start of string
    logic [PAGE_W-1:0] e_page;
    logic [COL_W-1:0]  e_col;
    logic              e_skip;
    logic              e_done;
    logic              is_cont;
    logic              wrap;
    logic              draw;
    logic [PAGE_W:0]   page_inc;

    always_comb begin
        e_page = i_first ? '0   : r_page;
        e_col  = i_first ? '0   : r_col;
        e_skip = i_first ? 1'b0 : r_skip;
        e_done = i_first ? 1'b0 : r_done;

        is_cont  = (i_char_code >= CHAR_HIGH) && (i_char_code <= CHAR_CONT_LAST);
        wrap     = (i_char_code == CHAR_LF) ||
                   (({1'b0, e_col} + (COL_W+1)'(GLYPH_ADVANCE)) > COL_LIMIT);
        page_inc = {1'b0, e_page} + (PAGE_W+1)'(1);

        n_page = e_page;
        n_col  = e_col;
        n_skip = e_skip;
        n_done = e_done;
        draw   = 1'b0;

        o_plan        = '0;
        o_plan.pkt    = {8'h00, font_row(glyph_index(i_char_code))};
        if (i_first) begin
            o_plan.cmds[2:0] = cursor_cmds('0, '0);
            o_plan.ncmd      = NCMD_W'(3);
        end

        // Per-byte handling once the string is live
        if (!e_done && !(e_skip && is_cont)) begin
            n_skip = 1'b0;
            if (i_char_code == CHAR_NUL) begin
                n_done = 1'b1;
            end else begin
                draw = 1'b1;
                if (wrap) begin
                    if (page_inc >= PAGE_LIMIT) begin
                        n_done = 1'b1;
                        draw   = 1'b0;
                    end else begin
                        n_page = page_inc[PAGE_W-1:0];
                        n_col  = '0;
                        if (i_first) begin
                            o_plan.cmds[5:3] = cursor_cmds(page_inc[PAGE_W-1:0], '0);
                        end else begin
                            o_plan.cmds[2:0] = cursor_cmds(page_inc[PAGE_W-1:0], '0);
                        end
                        o_plan.ncmd = o_plan.ncmd + NCMD_W'(3);
                        if (i_char_code == CHAR_LF) draw = 1'b0;
                    end
                end
                if (draw) begin
                    n_col  = n_col + COL_W'(GLYPH_ADVANCE);
                    n_skip = 1'b1;
                end
            end
        end
        o_plan.pkt_en = draw;
    end

    // Cursor state, updated as each byte is handed to the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page <= '0;
            r_col  <= '0;
            r_skip <= 1'b0;
            r_done <= 1'b1;
        end else if (i_load) begin
            r_page <= n_page;
            r_col  <= n_col;
            r_skip <= n_skip;
            r_done <= n_done;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/page_text_to_oled_write_stream.sv -----
// ----------------------------------------------------------------------------
// page_text_to_oled_write_stream
// Text bytes in, page-mode cursor commands and 6-byte glyph packets out.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+-----------------------------------
//  text in  | input     | i_valid / o_stall  | i_char_code, i_first
//  write out| output    | o_valid / i_stall  | o_is_command, o_command_byte,
//           |           |                    | o_glyph_packet, o_last
//
//  A byte is registered, expanded combinationally into 0 to 6 writes, and the
//  writes leave one per cycle from the output register while it is not
//  stalled, fed by the output sequencer; the next byte is loaded into the
//  sequencer as the last write of the current one enters the output register.
//  Reset is synchronous, active low; the text is idle until a first byte.
//  A stall on the output holds the current write and backs up the input.
// ----------------------------------------------------------------------------
`default_nettype none

module page_text_to_oled_write_stream
    import ptow_pkg::*;
#(
    parameter int SCREEN_COLUMNS = 128,
    parameter int SCREEN_PAGES   = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire logic [CHAR_W-1:0]   i_char_code,
    input  wire logic                i_first,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic                     o_is_command,
    output logic [7:0]               o_command_byte,
    output logic [PACKET_W-1:0]      o_glyph_packet,
    output logic                     o_last
);

    // Input register
    logic              r_s1_valid;
    logic [CHAR_W-1:0] r_s1_char;
    logic              r_s1_first;

    // Write sequencer
    t_cmd_list           r_cmd;
    logic [NCMD_W-1:0]   r_ncmd;
    logic                r_pkt_en;
    logic [PACKET_W-1:0] r_pkt;
    logic [NCMD_W-1:0]   r_idx;

    // Output register
    logic                r_o_valid;
    logic                r_o_is_cmd;
    logic [7:0]          r_o_cmd;
    logic [PACKET_W-1:0] r_o_pkt;
    logic                r_o_last;

    t_plan             plan;
    logic [NCMD_W-1:0] seq_total;
    logic [NCMD_W-1:0] idx_next;
    logic              seq_pending;
    logic              out_free;
    logic              emit;
    logic              emit_last;
    logic              emit_is_cmd;
    logic              s1_move;
    logic              in_take;

    ptow_plan #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_PAGES   (SCREEN_PAGES)
    ) u_plan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (s1_move),
        .i_char_code (r_s1_char),
        .i_first     (r_s1_first),
        .o_plan      (plan)
    );

    // Sequencer and handshake control
    always_comb begin
        seq_total   = r_ncmd + NCMD_W'(r_pkt_en);
        idx_next    = r_idx + NCMD_W'(1);
        seq_pending = (r_idx != seq_total);
        out_free    = !r_o_valid || !i_stall;
        emit        = seq_pending && out_free;
        emit_last   = (idx_next == seq_total);
        emit_is_cmd = (r_idx < r_ncmd);
        s1_move     = r_s1_valid && (!seq_pending || (emit && emit_last));
        o_stall     = r_s1_valid && !s1_move;
        in_take     = i_valid && !o_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_stall) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_char  <= i_char_code;
            r_s1_first <= i_first;
        end
    end

    // Load a new write list, or step through the current one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ncmd   <= '0;
            r_pkt_en <= 1'b0;
            r_idx    <= '0;
        end else if (s1_move) begin
            r_ncmd   <= plan.ncmd;
            r_pkt_en <= plan.pkt_en;
            r_idx    <= '0;
        end else if (emit) begin
            r_idx    <= idx_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_cmd <= plan.cmds;
            r_pkt <= plan.pkt;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_free) begin
            r_o_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_is_cmd <= emit_is_cmd;
            r_o_cmd    <= emit_is_cmd ? r_cmd[r_idx] : 8'h00;
            r_o_pkt    <= emit_is_cmd ? '0 : r_pkt;
            r_o_last   <= emit_last;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_is_command   = r_o_is_cmd;
    assign o_command_byte = r_o_cmd;
    assign o_glyph_packet = r_o_pkt;
    assign o_last         = r_o_last;

    // Checks
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= seq_total)
        else $error("sequencer index past end of write list");

    a_stall_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_s1_valid)
        else $error("input stalled with empty input register");

    a_packet_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_command) |-> o_last)
        else $error("glyph packet not the final write of its byte");

    a_list_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last) |=> o_valid)
        else $error("gap inside the write list of one byte");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the page-mode OLED text writer.
// A directed step list covers the glyph classes, the high-byte and continuation
// rules, newline, end of string and the idle state. Random strings follow,
// shaped to wrap lines and to run off the last page. Every write is checked
// against a behavioral copy of the cursor and font logic kept in this bench.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import ptow_pkg::*;

    localparam int SCREEN_COLUMNS = 128;
    localparam int SCREEN_PAGES   = 8;
    localparam int RANDOM_ITEMS   = 330;

    // One display write as seen on the output channel
    typedef struct packed {
        logic                is_cmd;
        logic [7:0]          cmd;
        logic [PACKET_W-1:0] pkt;
        logic                last;
    } t_text_write;

    // Directed step: typed rows carry their writes, the rest use the predictor.
    // Typed rows that carry writes start a string, at page 0, column 0.
    typedef struct packed {
        logic                first;
        logic [7:0]          code;
        logic                typed;
        logic                home_cursor;
        logic                has_pkt;
        logic [PACKET_W-1:0] pkt;
    } t_text_step;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    logic [CHAR_W-1:0]   i_char_code = '0;
    logic                i_first = 1'b0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    logic                o_is_command;
    logic [7:0]          o_command_byte;
    logic [PACKET_W-1:0] o_glyph_packet;
    logic                o_last;

    // Predictor state
    logic [PAGE_W-1:0]   cur_page = '0;
    logic [COL_W-1:0]    cur_col = '0;
    logic                skip_cont = 1'b0;
    logic                text_done = 1'b1;

    t_text_write         pending_writes[$];
    int                  mismatch_count = 0;
    int                  items_done = 0;
    logic                calm = 1'b0;

    page_text_to_oled_write_stream #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_PAGES   (SCREEN_PAGES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_char_code    (i_char_code),
        .i_first        (i_first),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_is_command   (o_is_command),
        .o_command_byte (o_command_byte),
        .o_glyph_packet (o_glyph_packet),
        .o_last         (o_last)
    );

    // 125 MHz clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Font slot for a byte; letters fold to upper case
    function automatic int slot_of_char(input logic [7:0] c);
        logic [7:0] u;
        u = (c >= CHAR_LO_A && c <= CHAR_LO_Z) ? c - CASE_OFFSET : c;
        if (c >= CHAR_HIGH) return int'(G_UNKNOWN);
        if (c == CHAR_SPACE) return int'(G_BLANK);
        if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(G_DIGIT) + int'(c - CHAR_ZERO);
        if (u >= CHAR_UP_A && u <= CHAR_UP_Z) return int'(G_LETTER) + int'(u - CHAR_UP_A);
        if (c == CHAR_DASH) return int'(G_DASH);
        if (c == CHAR_DOT) return int'(G_DOT);
        if (c == CHAR_COLON) return int'(G_COLON);
        if (c == CHAR_SLASH) return int'(G_SLASH);
        return int'(G_UNKNOWN);
    endfunction

    // Glyph columns in drawing order, column 0 in the top byte
    function automatic logic [39:0] font_columns(input int slot);
        case (slot)
            0:       return 40'h00_00_00_00_00;
            1:       return 40'h3E_51_49_45_3E;
            2:       return 40'h00_42_7F_40_00;
            3:       return 40'h42_61_51_49_46;
            4:       return 40'h21_41_45_4B_31;
            5:       return 40'h18_14_12_7F_10;
            6:       return 40'h27_45_45_45_39;
            7:       return 40'h3C_4A_49_49_30;
            8:       return 40'h01_71_09_05_03;
            9:       return 40'h36_49_49_49_36;
            10:      return 40'h06_49_49_29_1E;
            11:      return 40'h7E_11_11_11_7E;
            12:      return 40'h7F_49_49_49_36;
            13:      return 40'h3E_41_41_41_22;
            14:      return 40'h7F_41_41_22_1C;
            15:      return 40'h7F_49_49_49_41;
            16:      return 40'h7F_09_09_09_01;
            17:      return 40'h3E_41_49_49_7A;
            18:      return 40'h7F_08_08_08_7F;
            19:      return 40'h00_41_7F_41_00;
            20:      return 40'h20_40_41_3F_01;
            21:      return 40'h7F_08_14_22_41;
            22:      return 40'h7F_40_40_40_40;
            23:      return 40'h7F_02_0C_02_7F;
            24:      return 40'h7F_04_08_10_7F;
            25:      return 40'h3E_41_41_41_3E;
            26:      return 40'h7F_09_09_09_06;
            27:      return 40'h3E_41_51_21_5E;
            28:      return 40'h7F_09_19_29_46;
            29:      return 40'h46_49_49_49_31;
            30:      return 40'h01_01_7F_01_01;
            31:      return 40'h3F_40_40_40_3F;
            32:      return 40'h1F_20_40_20_1F;
            33:      return 40'h3F_40_38_40_3F;
            34:      return 40'h63_14_08_14_63;
            35:      return 40'h07_08_70_08_07;
            36:      return 40'h61_51_49_45_43;
            37:      return 40'h08_08_08_08_08;
            38:      return 40'h00_60_60_00_00;
            39:      return 40'h00_36_36_00_00;
            40:      return 40'h20_10_08_04_02;
            default: return 40'h02_01_51_09_06;
        endcase
    endfunction

    function automatic void push_write(input bit keep, input logic is_cmd,
                                       input logic [7:0] cmd,
                                       input logic [PACKET_W-1:0] pkt);
        t_text_write w;
        w.is_cmd = is_cmd;
        w.cmd    = cmd;
        w.pkt    = pkt;
        w.last   = 1'b0;
        if (keep) pending_writes.push_back(w);
    endfunction

    function automatic void push_cursor(input bit keep, input logic [PAGE_W-1:0] pg,
                                        input logic [COL_W-1:0] col);
        push_write(keep, 1'b1, CMD_PAGE | {4'b0, pg}, '0);
        push_write(keep, 1'b1, CMD_COL_LO | {4'b0, col[3:0]}, '0);
        push_write(keep, 1'b1, CMD_COL_HI | {5'b0, col[6:4]}, '0);
    endfunction

    // Advance the cursor model by one text byte and queue its writes
    function automatic void predict_writes(input logic f, input logic [7:0] c,
                                           input bit keep);
        bit          draw;
        int          n;
        logic [39:0] cols;
        n = 0;
        if (f) begin
            cur_page  = '0;
            cur_col   = '0;
            skip_cont = 1'b0;
            text_done = 1'b0;
            push_cursor(keep, cur_page, cur_col);
            n += 3;
        end
        if (!text_done) begin
            if (skip_cont && c >= CHAR_HIGH && c <= CHAR_CONT_LAST) begin
                // trailing UTF-8 byte of a drawn character: dropped
            end else if (c == CHAR_NUL) begin
                skip_cont = 1'b0;
                text_done = 1'b1;
            end else begin
                draw = 1'b1;
                skip_cont = 1'b0;
                // newline or no room left on this line
                if (c == CHAR_LF || int'(cur_col) + GLYPH_ADVANCE > SCREEN_COLUMNS) begin
                    if (int'(cur_page) + 1 >= SCREEN_PAGES) begin
                        text_done = 1'b1;
                        draw = 1'b0;
                    end else begin
                        cur_page = cur_page + 1'b1;
                        cur_col  = '0;
                        push_cursor(keep, cur_page, cur_col);
                        n += 3;
                        if (c == CHAR_LF) draw = 1'b0;
                    end
                end
                if (draw) begin
                    cols = font_columns(slot_of_char(c));
                    push_write(keep, 1'b0, 8'h00,
                               {8'h00, cols[7:0], cols[15:8], cols[23:16],
                                cols[31:24], cols[39:32]});
                    n += 1;
                    cur_col = cur_col + COL_W'(GLYPH_ADVANCE);
                    skip_cont = 1'b1;
                end
            end
        end
        if (keep && n > 0) pending_writes[pending_writes.size() - 1].last = 1'b1;
    endfunction

    // Offer one byte, with random idle cycles ahead of it, until accepted
    task automatic put_byte(input logic f, input logic [7:0] c, input bit keep);
        calm = (items_done >= 140 && items_done < 220);
        while (!calm && $urandom_range(0, 99) < 35) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_first     <= f;
        i_char_code <= c;
        do @(posedge i_clk); while (o_stall);
        predict_writes(f, c, keep);
        items_done++;
    endtask

    // Printable byte from the font, or any other 7-bit printable
    function automatic logic [7:0] pick_printable();
        case ($urandom_range(0, 5))
            0:       return 8'($urandom_range(CHAR_ZERO, CHAR_NINE));
            1:       return 8'($urandom_range(CHAR_UP_A, CHAR_UP_Z));
            2:       return 8'($urandom_range(CHAR_LO_A, CHAR_LO_Z));
            3:       return CHAR_SPACE;
            4: begin
                case ($urandom_range(0, 3))
                    0:       return CHAR_DASH;
                    1:       return CHAR_DOT;
                    2:       return CHAR_COLON;
                    default: return CHAR_SLASH;
                endcase
            end
            default: return 8'($urandom_range(8'h21, 8'h7E));
        endcase
    endfunction

    // One random string. Mode 0 fills lines until they wrap, mode 1 is heavy on
    // newlines to run off the last page, mode 2 is short mixed text.
    task automatic send_string(input int mode);
        int len;
        int lf_pct;
        int r;
        len    = (mode == 0) ? $urandom_range(25, 45) :
                 (mode == 1) ? $urandom_range(40, 90) : $urandom_range(1, 30);
        lf_pct = (mode == 0) ? 0 : (mode == 1) ? 20 : 6;
        put_byte(1'b1, ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                    : pick_printable(), 1'b1);
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < lf_pct) begin
                put_byte(1'b0, CHAR_LF, 1'b1);
            end else if (r < lf_pct + 8) begin
                // multi-byte UTF-8 sequence
                put_byte(1'b0, 8'($urandom_range(8'hC0, 8'hFF)), 1'b1);
                repeat ($urandom_range(1, 3))
                    put_byte(1'b0, 8'($urandom_range(CHAR_HIGH, CHAR_CONT_LAST)), 1'b1);
            end else if (r < lf_pct + 13) begin
                put_byte(1'b0, 8'($urandom_range(1, 255)), 1'b1);
            end else if (r < lf_pct + 15) begin
                put_byte(1'b0, 8'($urandom_range(CHAR_HIGH, CHAR_CONT_LAST)), 1'b1);
            end else if (r == 99) begin
                // restart in the middle of a string
                put_byte(1'b1, pick_printable(), 1'b1);
            end else begin
                put_byte(1'b0, pick_printable(), 1'b1);
            end
        end
        if ($urandom_range(0, 99) < 85) put_byte(1'b0, CHAR_NUL, 1'b1);
        // noise after the string; ignored if it was ended
        repeat ($urandom_range(0, 3)) put_byte(1'b0, 8'($urandom_range(0, 255)), 1'b1);
    endtask

    t_text_step steps [0:23] = '{
        // idle after reset: no writes
        '{1'b0, CHAR_UP_A,      1'b1, 1'b0, 1'b0, 48'h0},
        '{1'b1, CHAR_ZERO,      1'b1, 1'b1, 1'b1, 48'h00_3E_45_49_51_3E},
        '{1'b0, CHAR_NINE,      1'b0, 1'b0, 1'b0, 48'h0},
        '{1'b0, CHAR_UP_Z,      1'b0, 1'b0, 1'b0, 48'h0},
        '{1'b0, CHAR_LO_A,      1'b0, 1'b0, 1'b0, 48'h0},
        '{1'b0, CHAR_LO_Z,      1'b0, 1'b0, 1'b0, 48'h0},
        '{1'b0, CHAR_SPACE,     1'b0, 1'b0, 1'b0, 48'h0},
        '{1'b0, CHAR_DASH,      1'b0, 1'b0, 1'b0, 48'h0},
        '{1'b0, CHAR_DOT,       1'b0, 1'b0, 1'b0, 48'h0},
        '{1'b0, CHAR_COLON,     1'b0, 1'b0, 1'b0, 48'h0},
        '{1'b0, CHAR_SLASH,     1'b0, 1'b0, 1'b0, 48'h0},
        '{1'b0, 8'h01,          1'b0, 1'b0, 1'b0, 48'h0},
        '{1'b0, 8'hE2,          1'b0, 1'b0, 1'b0, 48'h0},
        '{1'b0, CHAR_HIGH,      1'b0, 1'b0, 1'b0, 48'h0},
        '{1'b0, CHAR_CONT_LAST, 1'b0, 1'b0, 1'b0, 48'h0},
        '{1'b0, 8'hC0,          1'b0, 1'b0, 1'b0, 48'h0},
        '{1'b0, CHAR_LF,        1'b0, 1'b0, 1'b0, 48'h0},
        '{1'b0, 8'h7F,          1'b0, 1'b0, 1'b0, 48'h0},
        '{1'b0, CHAR_NUL,       1'b0, 1'b0, 1'b0, 48'h0},
        // ignored once the string has ended
        '{1'b0, 8'h42,          1'b1, 1'b0, 1'b0, 48'h0},
        '{1'b1, 8'hFF,          1'b1, 1'b1, 1'b1, 48'h00_06_09_51_01_02},
        '{1'b0, CHAR_CONT_LAST, 1'b0, 1'b0, 1'b0, 48'h0},
        // empty string: cursor commands only
        '{1'b1, CHAR_NUL,       1'b1, 1'b1, 1'b0, 48'h0},
        '{1'b1, CHAR_LF,        1'b0, 1'b0, 1'b0, 48'h0}
    };

    // Stimulus and end of run
    initial begin
        int strings_sent;
        strings_sent = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (steps[k]) begin
            put_byte(steps[k].first, steps[k].code, !steps[k].typed);
            if (steps[k].typed) begin
                if (steps[k].home_cursor) push_cursor(1'b1, '0, '0);
                if (steps[k].has_pkt) push_write(1'b1, 1'b0, 8'h00, steps[k].pkt);
                if (steps[k].home_cursor || steps[k].has_pkt)
                    pending_writes[pending_writes.size() - 1].last = 1'b1;
            end
        end

        items_done = 0;
        while (items_done < RANDOM_ITEMS) begin
            send_string((strings_sent < 2) ? strings_sent : $urandom_range(0, 2));
            strings_sent++;
        end
        i_valid <= 1'b0;

        while (pending_writes.size() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Output side: random stall, compare each transaction with the oldest write
    always @(posedge i_clk) begin : write_check
        t_text_write w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_writes.size() == 0) begin
                $error("unexpected write: cmd=%0b byte=%h pkt=%h last=%0b",
                       o_is_command, o_command_byte, o_glyph_packet, o_last);
                mismatch_count++;
            end else begin
                w = pending_writes.pop_front();
                if (o_is_command !== w.is_cmd) begin
                    $error("is_command: expected %0b, got %0b", w.is_cmd, o_is_command);
                    mismatch_count++;
                end
                if (o_command_byte !== w.cmd) begin
                    $error("command_byte: expected %h, got %h", w.cmd, o_command_byte);
                    mismatch_count++;
                end
                if (o_glyph_packet !== w.pkt) begin
                    $error("glyph_packet: expected %h, got %h", w.pkt, o_glyph_packet);
                    mismatch_count++;
                end
                if (o_last !== w.last) begin
                    $error("last: expected %0b, got %0b", w.last, o_last);
                    mismatch_count++;
                end
            end
        end
        i_stall <= !calm && ($urandom_range(0, 99) < 35);
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire
